// ===== src/utf8_stream_decoder_assert.svh =====
// Assertion macros used by the port checker of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define UTF8SD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define UTF8SD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/utf8sd_pkg.sv =====
// Types and constants of the UTF-8 stream decoder.
package utf8sd_pkg;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_CONT_AS_LEAD = 2'd1,
		ST_TRUNCATED    = 2'd2,
		ST_BAD_CONT     = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} octet_t;

	typedef struct packed {
		logic [30:0] code_point;
		status_t     status;
		logic        string_end;
	} result_t;

	typedef struct packed {
		logic [2:0]  pending_count;
		logic [30:0] partial_code;
		logic        skipping;
	} dec_state_t;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] LEAD_5B = 8'hF8;
	localparam logic [7:0] LEAD_6B = 8'hFC;
	localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

// ===== src/utf8sd_dec.sv =====
// Decode step: next decoder state and optional result for one byte.
module utf8sd_dec (
	input  utf8sd_pkg::dec_state_t state,
	input  utf8sd_pkg::octet_t     octet,
	output utf8sd_pkg::dec_state_t next_state,
	output logic                   emit,
	output utf8sd_pkg::result_t    result
);
	import utf8sd_pkg::*;

	logic [7:0]  b;
	logic        last;
	logic        is_cont;
	logic [2:0]  lead_count;
	logic [4:0]  lead_bits;
	logic [30:0] shifted;
	logic [2:0]  pend_dec;

	assign b       = octet.in_byte;
	assign last    = octet.end_of_string;
	assign is_cont = (b[7:6] == CONT_TAG);
	assign shifted = {state.partial_code[24:0], b[5:0]};
	assign pend_dec = state.pending_count - 3'd1;

	// Bytes 0xFE and 0xFF fall in with the six-byte leads.
	always_comb begin
		if (b >= LEAD_6B) begin
			lead_count = 3'd5;
			lead_bits  = {4'b0, b[0]};
		end else if (b >= LEAD_5B) begin
			lead_count = 3'd4;
			lead_bits  = {3'b0, b[1:0]};
		end else if (b >= LEAD_4B) begin
			lead_count = 3'd3;
			lead_bits  = {2'b0, b[2:0]};
		end else if (b >= LEAD_3B) begin
			lead_count = 3'd2;
			lead_bits  = {1'b0, b[3:0]};
		end else begin
			lead_count = 3'd1;
			lead_bits  = b[4:0];
		end
	end

	always_comb begin
		next_state = state;
		emit       = 1'b0;
		result     = '{code_point: '0, status: ST_OK, string_end: last};
		if (state.skipping) begin
			next_state.skipping = !last;
		end else if (state.pending_count == 3'd0) begin
			if (!b[7]) begin
				emit              = 1'b1;
				result.code_point = {23'b0, b};
			end else if (is_cont) begin
				emit          = 1'b1;
				result.status = ST_CONT_AS_LEAD;
				next_state    = '{pending_count: '0, partial_code: '0, skipping: !last};
			end else if (last) begin
				emit          = 1'b1;
				result.status = ST_TRUNCATED;
				next_state    = '{pending_count: '0, partial_code: '0, skipping: 1'b0};
			end else begin
				next_state.pending_count = lead_count;
				next_state.partial_code  = {26'b0, lead_bits};
			end
		end else if (!is_cont) begin
			emit          = 1'b1;
			result.status = ST_BAD_CONT;
			next_state    = '{pending_count: '0, partial_code: '0, skipping: !last};
		end else if (pend_dec == 3'd0) begin
			emit              = 1'b1;
			result.code_point = shifted;
			next_state        = '{pending_count: '0, partial_code: '0, skipping: 1'b0};
		end else if (last) begin
			emit          = 1'b1;
			result.status = ST_TRUNCATED;
			next_state    = '{pending_count: '0, partial_code: '0, skipping: 1'b0};
		end else begin
			next_state.pending_count = pend_dec;
			next_state.partial_code  = shifted;
		end
	end

endmodule

// ===== src/utf8_stream_decoder.sv =====
// Top level of the six-byte UTF-8 stream decoder.
//
// Usage: the octet channel carries one raw byte per request with an end of
// string flag; the cp channel returns at most one result per byte: a code
// point of up to 31 bits with a status and the end of string flag.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. Lead and middle bytes of a character give no result.
// An error gives one result with a zero code point; unless the bad byte
// is end-marked, later bytes are dropped up to and including the next one.
// A byte taken is held in the input register and then decoded into the
// result register; a stall of the receiver can hold it in between.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single input register and result register with the decode logic between them.
// When the receiver stalls, the result holds and one more byte can still be
// taken into the input register; after that octet_stall rises.
// Reset clears the decoder state and both valid flags; octet_stall is then
// low, so the block is ready to take a byte once reset is released.
module utf8_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                octet_valid,
	output logic                octet_stall,
	input  utf8sd_pkg::octet_t  octet,
	output logic                cp_valid,
	input  logic                cp_stall,
	output utf8sd_pkg::result_t cp
);
	import utf8sd_pkg::*;

	logic       octet_v_s1;
	octet_t     octet_s1;
	dec_state_t state_q;
	dec_state_t next_state;
	logic       emit;
	result_t    result;
	logic       cp_v_s2;
	result_t    cp_s2;
	logic       s2_ready;
	logic       advance;
	logic       take;

	assign s2_ready    = !cp_v_s2 || !cp_stall;
	assign advance     = octet_v_s1 && s2_ready;
	assign octet_stall = octet_v_s1 && !s2_ready;
	assign take        = octet_valid && !octet_stall;

	utf8sd_dec u_dec (
		.state      (state_q),
		.octet      (octet_s1),
		.next_state (next_state),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_v_s1 <= 1'b0;
			cp_v_s2    <= 1'b0;
			state_q    <= '0;
		end else begin
			if (take) begin
				octet_v_s1 <= 1'b1;
			end else if (advance) begin
				octet_v_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= next_state;
				cp_v_s2 <= emit;
			end else if (s2_ready) begin
				cp_v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			octet_s1 <= octet;
		end
		if (advance && emit) begin
			cp_s2 <= result;
		end
	end

	assign cp_valid = cp_v_s2;
	assign cp       = cp_s2;

endmodule

// ===== src/utf8sd_chk.sv =====
// Port checker of the UTF-8 stream decoder and its bind to the top level.
`include "utf8_stream_decoder_assert.svh"

module utf8sd_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                octet_valid,
	input logic                octet_stall,
	input utf8sd_pkg::octet_t  octet,
	input logic                cp_valid,
	input logic                cp_stall,
	input utf8sd_pkg::result_t cp
);
	import utf8sd_pkg::*;

	`UTF8SD_ASSERT(a_cp_hold, cp_valid && cp_stall |=> cp_valid && $stable(cp), "stalled result changed")
	`UTF8SD_ASSERT(a_err_zero, cp_valid && cp.status != ST_OK |-> cp.code_point == 31'd0, "error with nonzero code point")
	`UTF8SD_ASSERT(a_trunc_end, cp_valid && cp.status == ST_TRUNCATED |-> cp.string_end, "truncation away from end of string")
	// Checks that the result valid flag is clear once reset has been held low across sampled edges.
	`UTF8SD_ASSERT_ALWAYS(a_reset_idle, !arst_n && $past(!arst_n) |-> !cp_valid, "result valid during reset")

endmodule

bind utf8_stream_decoder utf8sd_chk u_chk (.*);
